// ===== sv/topic_filter_match_table_unit_macros.svh =====
// Assertion macros for the topic filter match table.
// Included by the top level; the bodies are empty when SYNTH is defined.
`ifndef TOPIC_FILTER_MATCH_TABLE_UNIT_MACROS_SVH
`define TOPIC_FILTER_MATCH_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
`define TFM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("topic filter table check failed");
`define TFM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("topic filter table check failed");
`else
`define TFM_ASSERT_IMP(lbl, ante, cons)
`define TFM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/tfm_pkg.sv =====
// Shared types and constants of the topic filter match table.
// No dependencies.
package tfm_pkg;

	localparam int NUM_FILTERS_DFLT = 8;
	localparam int FILTER_LEN_DFLT = 64;

	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [1:0] {
		OP_WR_CHAR = 2'd0,
		OP_SET_EN = 2'd1,
		OP_TOPIC = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_CMP = 2'd0,
		MODE_PLUS = 2'd1,
		MODE_ACCEPT = 2'd2,
		MODE_FAIL = 2'd3
	} mode_t;

endpackage

// ===== sv/tfm_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// Reads return the old contents when a port reads the address being written.
module tfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_q[rd_addr_a];
		rd_b_q <= mem_q[rd_addr_b];
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

// ===== sv/topic_filter_match_table_unit.sv =====
// Topic filter match table: filter storage, per-entry matchers and result stage.
// Depends on tfm_pkg, tfm_ram and topic_filter_match_table_unit_macros.svh.
//
// After reset the block clears its filter memories address by address and holds
// item_stall high meanwhile. From then on it takes one word per cycle while
// item_stall is low: filter character writes, enable writes and topic characters
// alike. Each entry keeps the filter character at its cursor in a register and
// reads the next two from its own RAM through two registered read ports, so every
// entry steps over each accepted topic character without waiting on a read. The
// result of a topic is formed as its final character is accepted and registered
// into a two-deep output stage, which keeps the input open while one result waits.
`include "topic_filter_match_table_unit_macros.svh"

module topic_filter_match_table_unit #(
	parameter int NUM_FILTERS = tfm_pkg::NUM_FILTERS_DFLT,
	parameter int FILTER_LEN = tfm_pkg::FILTER_LEN_DFLT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  tfm_pkg::op_t opcode,
	input  logic [2:0]   entry_index,
	input  logic [5:0]   char_pos,
	input  logic [7:0]   char_value,
	input  logic         enable_value,
	input  logic         topic_last,
	output logic         result_valid,
	input  logic         result_stall,
	output logic         matched,
	output logic [2:0]   match_index
);

	import tfm_pkg::*;

	localparam int AW = $clog2(FILTER_LEN);
	localparam int CW = $clog2(FILTER_LEN + 1);
	localparam int XW = CW + 2;
	localparam logic [XW-1:0] LEN_X = XW'(FILTER_LEN);

	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	mode_t         mode_q  [NUM_FILTERS];
	logic [CW-1:0] cur_q   [NUM_FILTERS];
	logic [7:0]    c0_q    [NUM_FILTERS];
	logic [7:0]    head_q  [NUM_FILTERS];
	logic          en_q    [NUM_FILTERS];
	logic          byp_a_q [NUM_FILTERS];
	logic          byp_b_q [NUM_FILTERS];
	logic [7:0]    bdata_q [NUM_FILTERS];
	logic [7:0]    rd_a    [NUM_FILTERS];
	logic [7:0]    rd_b    [NUM_FILTERS];
	logic          fin     [NUM_FILTERS];

	logic item_acc;
	logic topic_acc;
	logic wr_acc;
	logic en_acc;
	logic pos_ok;
	logic res_push;
	logic res_matched;
	logic [2:0] res_index;
	logic any_cur_nz;

	logic       out_valid_q;
	logic       out_matched_q;
	logic [2:0] out_index_q;
	logic       skid_valid_q;
	logic       skid_matched_q;
	logic [2:0] skid_index_q;
	logic       out_pop;

	assign item_stall = clearing_q || skid_valid_q;
	assign item_acc = item_valid && !item_stall;
	assign topic_acc = item_acc && (opcode == OP_TOPIC);
	assign wr_acc = item_acc && (opcode == OP_WR_CHAR);
	assign en_acc = item_acc && (opcode == OP_SET_EN);
	assign pos_ok = 32'(char_pos) < 32'(FILTER_LEN);
	assign res_push = topic_acc && topic_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(FILTER_LEN - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	for (genvar g = 0; g < NUM_FILTERS; g++) begin : g_ent
		logic [7:0]    c1;
		logic [7:0]    c2;
		logic [7:0]    c0_adv;
		logic          v0;
		logic          v1;
		logic          v2;
		logic          v0_adv;
		logic [XW-1:0] cur_x;
		logic [XW-1:0] cur_adv_x;
		logic [XW-1:0] nx_x;
		logic [XW-1:0] ra_a_x;
		logic [XW-1:0] ra_b_x;
		logic [1:0]    step;
		mode_t         mode_adv;
		logic          sel_wr;
		logic          sel_en;
		logic          we;
		logic [AW-1:0] wa;
		logic [7:0]    wd;
		logic [AW-1:0] ra_a;
		logic [AW-1:0] ra_b;

		always_comb begin
			c1 = byp_a_q[g] ? bdata_q[g] : rd_a[g];
			c2 = byp_b_q[g] ? bdata_q[g] : rd_b[g];
			cur_x = XW'(cur_q[g]);
			v0 = cur_x < LEN_X;
			v1 = (cur_x + XW'(1)) < LEN_X;
			v2 = (cur_x + XW'(2)) < LEN_X;
			step = 2'd0;
			mode_adv = mode_q[g];
			unique case (mode_q[g])
				MODE_CMP: begin
					if (!v0 || c0_q[g] == CH_NUL) begin
						mode_adv = MODE_FAIL;
					end else if (c0_q[g] == CH_PLUS) begin
						if (char_value == CH_SLASH) begin
							if (!v1 || c1 == CH_NUL) begin
								step = 2'd1;
								mode_adv = MODE_FAIL;
							end else begin
								step = 2'd2;
								mode_adv = (c1 == CH_SLASH && v2 && c2 == CH_HASH) ?
									MODE_ACCEPT : MODE_CMP;
							end
						end else begin
							step = 2'd1;
							mode_adv = MODE_PLUS;
						end
					end else if (c0_q[g] != char_value) begin
						mode_adv = MODE_FAIL;
					end else begin
						step = 2'd1;
						mode_adv = (c0_q[g] == CH_SLASH && v1 && c1 == CH_HASH) ?
							MODE_ACCEPT : MODE_CMP;
					end
				end
				MODE_PLUS: begin
					if (char_value == CH_SLASH) begin
						if (!v0 || c0_q[g] == CH_NUL) begin
							mode_adv = MODE_FAIL;
						end else begin
							step = 2'd1;
							mode_adv = (c0_q[g] == CH_SLASH && v1 && c1 == CH_HASH) ?
								MODE_ACCEPT : MODE_CMP;
						end
					end
				end
				MODE_ACCEPT: begin
				end
				MODE_FAIL: begin
				end
			endcase
			cur_adv_x = cur_x + XW'(step);
			unique case (step)
				2'd0: c0_adv = c0_q[g];
				2'd1: c0_adv = c1;
				default: c0_adv = c2;
			endcase
			v0_adv = cur_adv_x < LEN_X;
			fin[g] = (mode_adv == MODE_ACCEPT) ||
				((mode_adv == MODE_CMP || mode_adv == MODE_PLUS) && v0_adv &&
				c0_adv == CH_NUL);

			if (topic_acc) begin
				nx_x = topic_last ? '0 : cur_adv_x;
			end else begin
				nx_x = cur_x;
			end
			ra_a_x = nx_x + XW'(1);
			ra_b_x = nx_x + XW'(2);
			ra_a = (ra_a_x < LEN_X) ? AW'(ra_a_x) : '0;
			ra_b = (ra_b_x < LEN_X) ? AW'(ra_b_x) : '0;

			sel_wr = wr_acc && pos_ok && (32'(entry_index) == g);
			sel_en = en_acc && (32'(entry_index) == g);
			we = clearing_q || sel_wr;
			wa = clearing_q ? clr_addr_q : AW'(char_pos);
			wd = clearing_q ? CH_NUL : char_value;
		end

		tfm_ram #(
			.WIDTH(8),
			.DEPTH(FILTER_LEN)
		) u_ram (
			.clk(clk),
			.wr_en(we),
			.wr_addr(wa),
			.wr_data(wd),
			.rd_addr_a(ra_a),
			.rd_data_a(rd_a[g]),
			.rd_addr_b(ra_b),
			.rd_data_b(rd_b[g])
		);

		always_ff @(posedge clk) begin
			bdata_q[g] <= wd;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mode_q[g] <= MODE_CMP;
				cur_q[g] <= '0;
				c0_q[g] <= CH_NUL;
				head_q[g] <= CH_NUL;
				en_q[g] <= 1'b0;
				byp_a_q[g] <= 1'b0;
				byp_b_q[g] <= 1'b0;
			end else begin
				byp_a_q[g] <= we && (wa == ra_a);
				byp_b_q[g] <= we && (wa == ra_b);
				if (topic_acc) begin
					if (topic_last) begin
						mode_q[g] <= MODE_CMP;
						cur_q[g] <= '0;
						c0_q[g] <= head_q[g];
					end else begin
						mode_q[g] <= mode_adv;
						cur_q[g] <= CW'(cur_adv_x);
						c0_q[g] <= c0_adv;
					end
				end else if (sel_wr) begin
					if (32'(char_pos) == 32'(cur_q[g])) begin
						c0_q[g] <= char_value;
					end
					if (char_pos == 6'd0) begin
						head_q[g] <= char_value;
					end
				end
				if (sel_en) begin
					en_q[g] <= enable_value;
				end
			end
		end
	end

	always_comb begin
		res_matched = 1'b0;
		res_index = 3'd0;
		for (int i = NUM_FILTERS - 1; i >= 0; i--) begin
			if (en_q[i] && fin[i]) begin
				res_matched = 1'b1;
				res_index = 3'(i);
			end
		end
	end

	always_comb begin
		any_cur_nz = 1'b0;
		for (int i = 0; i < NUM_FILTERS; i++) begin
			any_cur_nz = any_cur_nz || (cur_q[i] != '0);
		end
	end

	assign out_pop = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_matched_q <= 1'b0;
			out_index_q <= 3'd0;
			skid_valid_q <= 1'b0;
			skid_matched_q <= 1'b0;
			skid_index_q <= 3'd0;
		end else if (skid_valid_q) begin
			if (out_pop) begin
				out_matched_q <= skid_matched_q;
				out_index_q <= skid_index_q;
				skid_valid_q <= 1'b0;
			end
		end else if (res_push) begin
			if (!out_valid_q || out_pop) begin
				out_valid_q <= 1'b1;
				out_matched_q <= res_matched;
				out_index_q <= res_index;
			end else begin
				skid_valid_q <= 1'b1;
				skid_matched_q <= res_matched;
				skid_index_q <= res_index;
			end
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign matched = out_matched_q;
	assign match_index = out_index_q;

	`TFM_ASSERT_IMP(a_skid_needs_out, skid_valid_q, out_valid_q)
	`TFM_ASSERT_NXT(a_topic_end_rewinds, res_push, !any_cur_nz)
	`TFM_ASSERT_IMP(a_clear_idle, clearing_q, item_stall && !any_cur_nz && !out_valid_q)

endmodule
